FILE: design/wspf_pkg.sv
// Shared types and constants of the waveform segment peak finder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wspf_pkg;

  // Field widths of the streams and the register.
  localparam int SAMPLE_W   = 12;
  localparam int INDEX_W    = 8;
  localparam int THR_W      = 12;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // Configuration port geometry; bit 2 of the address selects the register.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_NOISE_THRESHOLD = 1'b0;

  // Result queue geometry. A request is taken only while the queue holds at
  // most FIFO_ROOM_MAX entries, which leaves room for two items of two
  // results each.
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_PTR_W    = 3;
  localparam int FIFO_CNT_W    = 4;
  localparam int FIFO_ROOM_MAX = 4;

  // One result.
  typedef struct packed {
    logic [INDEX_W-1:0]  peak_index;
    logic [SAMPLE_W-1:0] peak_height;
    logic                final_peak;
  } wspf_res_t;

  // Up to two results written by the core in one cycle, first in res_a.
  typedef struct packed {
    logic      push_a;
    logic      push_b;
    wspf_res_t res_a;
    wspf_res_t res_b;
  } wspf_push_t;

endpackage

`default_nettype wire

FILE: design/wspf_core.sv
// Segment tracking core: input register, segment state and result decision.
// Depends on wspf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wspf_core
  import wspf_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_SAMPLES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                acc,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                last,
  input  wire logic [THR_W-1:0]    noise_threshold,
  output wspf_push_t               push
);

  localparam int CNT_W = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam int EXT_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // Input register.
  logic                stg_valid_r;
  logic [SAMPLE_W-1:0] stg_sample_r;
  logic                stg_last_r;

  // Segment state.
  logic                seg_open_r,   seg_open_nxt;
  logic [SAMPLE_W-1:0] prev_r,       prev_nxt;
  logic [SAMPLE_W-1:0] max_r,        max_nxt;
  logic [CNT_W-1:0]    max_idx_r,    max_idx_nxt;
  logic                falling_r,    falling_nxt;
  logic [CNT_W-1:0]    cnt_r,        cnt_nxt;

  logic [SAMPLE_W-1:0] mask;
  logic [SAMPLE_W:0]   diff_dn;
  logic [SAMPLE_W:0]   diff_up;
  logic                drop_gt;
  logic                rise_gt;
  logic                fall;
  logic                close_seg;
  logic [EXT_W-1:0]    idx_old_ext;
  logic [EXT_W-1:0]    idx_new_ext;
  wspf_res_t           res_closed;
  wspf_res_t           res_final;

  // Keep only the sample bits the converter delivers.
  always_comb begin
    for (int i = 0; i < SAMPLE_W; i++) begin
      mask[i] = (i < SAMPLE_BITS);
    end
  end

  // Capture an accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= acc;
    end
    if (acc) begin
      stg_sample_r <= sample & mask;
      stg_last_r   <= last;
    end
  end

  // Threshold compares against the previous sample.
  assign diff_dn   = {1'b0, prev_r} - {1'b0, stg_sample_r};
  assign diff_up   = {1'b0, stg_sample_r} - {1'b0, prev_r};
  assign drop_gt   = !diff_dn[SAMPLE_W] && (diff_dn[SAMPLE_W-1:0] > noise_threshold);
  assign rise_gt   = !diff_up[SAMPLE_W] && (diff_up[SAMPLE_W-1:0] > noise_threshold);
  assign fall      = falling_r || drop_gt;
  assign close_seg = seg_open_r && fall && rise_gt;

  // Next segment state for the registered sample.
  always_comb begin
    seg_open_nxt = seg_open_r;
    prev_nxt     = prev_r;
    max_nxt      = max_r;
    max_idx_nxt  = max_idx_r;
    falling_nxt  = falling_r;
    cnt_nxt      = cnt_r;
    if (stg_valid_r) begin
      if (!seg_open_r || close_seg) begin
        seg_open_nxt = 1'b1;
        prev_nxt     = stg_sample_r;
        max_nxt      = stg_sample_r;
        max_idx_nxt  = cnt_r;
        falling_nxt  = 1'b0;
      end else begin
        if (stg_sample_r > max_r) begin
          max_nxt     = stg_sample_r;
          max_idx_nxt = cnt_r;
        end
        prev_nxt    = stg_sample_r;
        falling_nxt = fall;
      end
      if (stg_last_r) begin
        seg_open_nxt = 1'b0;
        falling_nxt  = 1'b0;
        cnt_nxt      = '0;
      end else if (cnt_r == CNT_W'(MAX_SAMPLES - 1)) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // Results: the segment closed by a rise, then the one the final sample ends.
  assign idx_old_ext = EXT_W'(max_idx_r);
  assign idx_new_ext = EXT_W'(max_idx_nxt);

  always_comb begin
    res_closed.peak_index  = idx_old_ext[INDEX_W-1:0];
    res_closed.peak_height = max_r;
    res_closed.final_peak  = 1'b0;
    res_final.peak_index   = idx_new_ext[INDEX_W-1:0];
    res_final.peak_height  = max_nxt;
    res_final.final_peak   = 1'b1;

    push.push_a = stg_valid_r && (close_seg || stg_last_r);
    push.push_b = stg_valid_r && close_seg && stg_last_r;
    push.res_a  = close_seg ? res_closed : res_final;
    push.res_b  = res_final;
  end

  // Segment state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_open_r <= 1'b0;
      prev_r     <= '0;
      max_r      <= '0;
      max_idx_r  <= '0;
      falling_r  <= 1'b0;
      cnt_r      <= '0;
    end else begin
      seg_open_r <= seg_open_nxt;
      prev_r     <= prev_nxt;
      max_r      <= max_nxt;
      max_idx_r  <= max_idx_nxt;
      falling_r  <= falling_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/wspf_fifo.sv
// Result queue: takes up to two results a cycle, hands out one per request.
// Depends on wspf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wspf_fifo
  import wspf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire wspf_push_t push,
  input  wire logic       pop,
  output logic            not_empty,
  output logic            room,
  output wspf_res_t       head
);

  wspf_res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r,  count_nxt;
  logic [FIFO_PTR_W-1:0]   wr_ptr_b;
  logic                    do_pop;

  assign not_empty = (count_r != '0);
  assign room      = (count_r <= FIFO_CNT_W'(FIFO_ROOM_MAX));
  assign head      = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;
  assign wr_ptr_b  = wr_ptr_r + 1'b1;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.push_a) + FIFO_PTR_W'(push.push_b);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(do_pop);
    count_nxt  = count_r + FIFO_CNT_W'(push.push_a) + FIFO_CNT_W'(push.push_b)
                 - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage; the second result goes to the slot after the first.
  always_ff @(posedge clk) begin
    if (push.push_a) begin
      mem_r[wr_ptr_r] <= push.res_a;
    end
    if (push.push_b) begin
      mem_r[wr_ptr_b] <= push.res_b;
    end
  end

endmodule

`default_nettype wire

FILE: design/waveform_segment_peak_finder_top.sv
// Top level of the waveform segment peak finder: streams, register port.
// Depends on wspf_pkg, wspf_core and wspf_fifo.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one ADC sample per cycle on the in_ stream while in_tready
// is high and reports, for every segment of the waveform (a rise followed by
// a fall, split where the signal has dropped and then rises by more than the
// noise threshold), the first greatest sample and its index on the out_
// stream. A sample is decided while it sits in the input register; its
// results are then written into the result queue and offered from its head.
// The sustained rate is one sample per cycle; the final sample of a waveform
// that also closes a segment gives two results, which leave on the out_
// stream one after the other. in_tready drops when the eight-entry result
// queue holds more than four results.
// noise_threshold lies at byte address 0 and should only be written while
// the block is idle.
module waveform_segment_peak_finder_top
  import wspf_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_SAMPLES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Sample stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [11:0] adc_sample, rest zero
  input  wire logic                  in_tlast,   // last_sample
  // Peak stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [7:0] peak_index, [19:8] peak_height
  output logic                       out_tlast,  // final_peak
  // Register port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  logic [THR_W-1:0] thr_r;
  logic             in_acc;
  logic             room;
  logic             not_empty;
  wspf_push_t       push;
  wspf_res_t        head;

  // Noise threshold register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_NOISE_THRESHOLD) ?
                      CFG_DATA_W'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_NOISE_THRESHOLD)) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  // Input handshake.
  assign in_tready = room;
  assign in_acc    = in_tvalid && room;

  wspf_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc             (in_acc),
    .sample          (in_tdata[SAMPLE_W-1:0]),
    .last            (in_tlast),
    .noise_threshold (thr_r),
    .push            (push)
  );

  wspf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_tready),
    .not_empty (not_empty),
    .room      (room),
    .head      (head)
  );

  // Output packing.
  assign out_tvalid = not_empty;
  assign out_tdata  = {(OUT_DATA_W - INDEX_W - SAMPLE_W)'(0), head.peak_height,
                       head.peak_index};
  assign out_tlast  = head.final_peak;

endmodule

`default_nettype wire

FILE: tb/wspf_peak_checker.sv
// Scoreboard for the waveform segment peak finder: tracks every accepted sample
// request, predicts the peaks it closes and compares them with the peak stream.
// Depends on wspf_pkg for field widths, the register index and the result type.
`timescale 1ns / 1ps

module wspf_peak_checker
  import wspf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [11:0] adc_sample, rest zero
  input  wire logic                  in_tlast,   // last_sample
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] peak_index, [19:8] peak_height
  input  wire logic                  out_tlast,  // final_peak
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic                  cfg_pready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                         mismatch_count,
  output int                         peaks_pending
);

  localparam int MAX_REPORTS = 40;

  // Shadow copy of the threshold register and the segment tracker.
  logic [THR_W-1:0]    noise_thr;
  logic                seg_open;
  logic [SAMPLE_W-1:0] prev_sample;
  logic [SAMPLE_W-1:0] seg_max;
  logic [INDEX_W-1:0]  seg_max_idx;
  logic [INDEX_W-1:0]  sample_idx;
  logic                falling;

  wspf_res_t expected_peaks[$];
  int        errors = 0;

  function automatic wspf_res_t segment_peak(input logic fin);
    wspf_res_t p;
    p.peak_index  = seg_max_idx;
    p.peak_height = seg_max;
    p.final_peak  = fin;
    return p;
  endfunction

  task automatic open_segment(input logic [SAMPLE_W-1:0] sample);
    seg_open    = 1'b1;
    prev_sample = sample;
    seg_max     = sample;
    seg_max_idx = sample_idx;
    falling     = 1'b0;
  endtask

  // Advance the segment tracker by one sample and queue the peaks it closes.
  task automatic track_sample(input logic [SAMPLE_W-1:0] sample, input logic last);
    int   drop;
    int   rise;
    logic fall;
    drop = int'(prev_sample) - int'(sample);
    rise = -drop;
    if (!seg_open) begin
      open_segment(sample);
    end else begin
      fall = falling || (drop > int'(noise_thr));
      if (fall && rise > int'(noise_thr)) begin
        // A rise after a fall closes the segment and opens the next one.
        expected_peaks = {expected_peaks, segment_peak(1'b0)};
        open_segment(sample);
      end else begin
        // Strictly greater only, so the first of equal maxima is kept.
        if (sample > seg_max) begin
          seg_max     = sample;
          seg_max_idx = sample_idx;
        end
        prev_sample = sample;
        falling     = fall;
      end
    end
    // The final sample closes whatever segment is open and restarts the index.
    if (last) begin
      expected_peaks = {expected_peaks, segment_peak(1'b1)};
      seg_open   = 1'b0;
      falling    = 1'b0;
      sample_idx = '0;
    end else begin
      sample_idx = sample_idx + 1'b1;
    end
  endtask

  task automatic report(input string what, input wspf_res_t want, input wspf_res_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s: expected index %0d height %0d final %0b, got index %0d height %0d final %0b",
               $time, what, want.peak_index, want.peak_height, want.final_peak,
               got.peak_index, got.peak_height, got.final_peak);
  endtask

  // Compare one peak request with the oldest prediction.
  task automatic check_peak();
    wspf_res_t got;
    wspf_res_t want;
    got.peak_index  = out_tdata[INDEX_W-1:0];
    got.peak_height = out_tdata[INDEX_W +: SAMPLE_W];
    got.final_peak  = out_tlast;
    if (expected_peaks.size() == 0) begin
      want = '0;
      report("peak with none expected", want, got);
    end else begin
      want = expected_peaks.pop_front();
      if (got.peak_index != want.peak_index || got.peak_height != want.peak_height ||
          got.final_peak != want.final_peak || out_tdata[OUT_DATA_W-1:INDEX_W+SAMPLE_W] != '0)
        report("peak mismatch", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      noise_thr   = '0;
      seg_open    = 1'b0;
      prev_sample = '0;
      seg_max     = '0;
      seg_max_idx = '0;
      sample_idx  = '0;
      falling     = 1'b0;
      expected_peaks.delete();
    end else begin
      // Only the threshold index is decoded; writes elsewhere are dropped.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_NOISE_THRESHOLD)
        noise_thr = cfg_pwdata[THR_W-1:0];
      if (in_tvalid && in_tready)
        track_sample(in_tdata[SAMPLE_W-1:0], in_tlast);
      if (out_tvalid && out_tready)
        check_peak();
    end
    mismatch_count <= errors;
    peaks_pending  <= expected_peaks.size();
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the waveform segment peak finder: clock, reset, sample and
// register stimulus, peak stream back-pressure and the verdict.
// Depends on wspf_pkg, waveform_segment_peak_finder_top and wspf_peak_checker.
`timescale 1ns / 1ps

module tb_top;
  import wspf_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 10;
  localparam int END_CYCLES    = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 125;
  localparam int NUM_PHASES    = 8;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

  // Byte addresses of the threshold register and of an undecoded slot.
  localparam logic [CFG_ADDR_W-1:0] ADDR_THRESHOLD = {REG_NOISE_THRESHOLD, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE     = {~REG_NOISE_THRESHOLD, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [11:0] adc_sample, rest zero
  logic                  in_tlast;   // last_sample
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [7:0] peak_index, [19:8] peak_height
  logic                  out_tlast;  // final_peak
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatches;
  int peaks_pending;
  int hold_token = 0;
  bit no_gaps = 1'b0;

  waveform_segment_peak_finder_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  wspf_peak_checker peak_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_pready     (cfg_pready),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .mismatch_count (mismatches),
    .peaks_pending  (peaks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, some short ones and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One sample request; waits for the edge where it was taken, then for a random gap.
  task automatic send_sample(input int value, input bit last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(value);
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_waveform(input int samples[$]);
    foreach (samples[i]) send_sample(samples[i], i == samples.size() - 1);
  endtask

  // Random walk with steps around the threshold so that falls and rises both
  // cross it; a few waveforms are plain noise.
  task automatic play_waveform(input int len, input int thr);
    int level;
    int dir;
    int s;
    int kind;
    bit noisy;
    level = $urandom_range(0, SAMPLE_MAX);
    dir   = 1;
    noisy = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 19);
      if (noisy || kind == 0) begin
        s = $urandom_range(0, SAMPLE_MAX);
      end else if (kind == 1) begin
        s = level;
      end else begin
        if ($urandom_range(0, 3) == 0) dir = -dir;
        s = level + dir * $urandom_range(0, 2 * thr + 16);
        if (s > SAMPLE_MAX) begin
          s   = SAMPLE_MAX;
          dir = -1;
        end else if (s < 0) begin
          s   = 0;
          dir = 1;
        end
      end
      level = s;
      send_sample(s, i == len - 1);
    end
  endtask

  // Register write: setup phase, then access phase until pready.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending, wait for every predicted peak, then let the pipeline empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (peaks_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Peak stream back-pressure, with one long hold-off on request.
  initial begin
    int  hold_left;
    int  stall_left;
    int  run_left;
    int  hold_seen;
    int  r;
    bit  steady;
    hold_left  = 0;
    stall_left = 0;
    run_left   = 0;
    hold_seen  = 0;
    steady     = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (run_left == 0) begin
        run_left = $urandom_range(20, 120);
        steady   = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_tready <= 1'b1;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
          out_tready <= 1'b0;
        end
      end
    end
  end

  // Watchdog: ends the run when no request moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // Main stimulus.
  initial begin
    int thr_list[NUM_PHASES];
    int phase_items;
    int len;
    int r;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A write to the undecoded slot must leave the threshold at zero.
    write_reg(ADDR_SPARE, SAMPLE_MAX);
    write_reg(ADDR_THRESHOLD, 0);
    // Single-sample waveform at full scale.
    send_waveform('{SAMPLE_MAX});
    // Rise, fall, tie, closing rise; the final sample also closes by rising.
    send_waveform('{0, SAMPLE_MAX, 100, 100, 200, 150, 0, 3000});
    // Flat waveform: the first of the equal maxima wins.
    send_waveform('{7, 7, 7});
    settle();

    // Steps up to the threshold do not count; a drop and a rise of one more close the segment.
    write_reg(ADDR_THRESHOLD, 100);
    send_waveform('{0, 50, 0, 100, 300, 199, 300});
    settle();

    thr_list = '{SAMPLE_MAX, 0, 1, $urandom_range(2, 40), $urandom_range(41, 400), 2000,
                 $urandom_range(0, SAMPLE_MAX), 12};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(ADDR_THRESHOLD, thr_list[p]);
      // Long receiver hold-off while samples keep coming.
      if (p == 1) hold_token <= hold_token + 1;
      phase_items = 0;
      // One waveform longer than the index range so that it wraps.
      if (p == 3) begin
        play_waveform(300, thr_list[p]);
        phase_items = 300;
      end
      while (phase_items < PHASE_ITEMS) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 19);
        len = (r == 0) ? 1 : (r == 1) ? $urandom_range(40, 80) : $urandom_range(2, 24);
        play_waveform(len, thr_list[p]);
        phase_items += len;
      end
      settle();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && peaks_pending == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: files.f
design/wspf_pkg.sv
design/wspf_core.sv
design/wspf_fifo.sv
design/waveform_segment_peak_finder_top.sv
tb/wspf_peak_checker.sv
tb/tb_top.sv
